// File: rtl/core/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared widths, defaults and controller/datapath command and status types
// for the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package kss_pkg;

   localparam int VALUE_W            = 32;
   localparam int WINDOW_W           = 4;
   localparam int DEFAULT_MAX_WINDOW = 15;

   typedef struct packed {
      logic capture;
      logic pop;
      logic final_flag;
      logic insert;
   } kss_cmd_type;

   typedef struct packed {
      logic at_capacity;
      logic single_left;
      logic out_free;
   } kss_status_type;

endpackage

// File: rtl/core/kss_channels.sv
// ----------------------------------------------------------------------------
// kss_channels
// Valid/ready channel interfaces for requests, results and the window
// register write port.
// ----------------------------------------------------------------------------
interface kss_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [kss_pkg::VALUE_W-1:0] value;
   logic                              final_item;

   modport source (output valid, output value, output final_item, input ready);
   modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface kss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [kss_pkg::VALUE_W-1:0] sorted_value;
   logic                              final_result;

   modport source (output valid, output sorted_value, output final_result, input ready);
   modport sink   (input valid, input sorted_value, input final_result, output ready);
endinterface

interface kss_csr_if;
   logic                         valid;
   logic                         ready;
   logic [kss_pkg::WINDOW_W-1:0] window;

   modport source (output valid, output window, input ready);
   modport sink   (input valid, input window, output ready);
endinterface

// File: rtl/core/kss_datapath.sv
// ----------------------------------------------------------------------------
// kss_datapath
// Sorted register chain with parallel insert and shift-down pop, the window
// register and the result output register.
// ----------------------------------------------------------------------------
module kss_datapath #(
   parameter int MAX_WINDOW = kss_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kss_pkg::kss_cmd_type               cmd,
   output kss_pkg::kss_status_type            status,
   input  logic signed [kss_pkg::VALUE_W-1:0] in_value,
   input  logic                               csr_valid,
   input  logic [kss_pkg::WINDOW_W-1:0]       csr_window,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [kss_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                               rsp_final_result
);
   import kss_pkg::*;

   localparam int DEPTH = MAX_WINDOW + 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int KW    = (CW > WINDOW_W) ? CW : WINDOW_W;

   logic signed [VALUE_W-1:0] entry_ff [DEPTH];
   logic signed [VALUE_W-1:0] entry_in [DEPTH];
   logic [CW-1:0]             count_ff, count_in;
   logic [WINDOW_W-1:0]       window_ff;
   logic signed [VALUE_W-1:0] hold_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_final_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [DEPTH-1:0]          greater;
   logic [KW-1:0]             win_ext, max_ext, limit;

   always_comb begin
      win_ext = KW'(window_ff);
      max_ext = KW'(MAX_WINDOW);
      limit   = (win_ext > max_ext) ? max_ext : win_ext;
   end

   always_comb begin
      status.at_capacity = KW'(count_ff) > limit;
      status.single_left = count_ff == CW'(1);
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         greater[i] = (CW'(i) < count_ff) && (entry_ff[i] > hold_ff);
      end
   end

   always_comb begin
      logic shift;
      logic place;
      shift    = 1'b0;
      place    = 1'b0;
      count_in = count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (cmd.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         count_in = count_ff - CW'(1);
      end else if (cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            shift = 1'b0;
            if (i > 0) begin
               shift = (CW'(i) <= count_ff) && greater[i - 1];
            end
            place = (CW'(i) <= count_ff) && !shift && (greater[i] || CW'(i) == count_ff);
            if (shift) begin
               entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
            end else if (place) begin
               entry_in[i] = hold_ff;
            end
         end
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      priority if (cmd.pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         window_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            window_ff <= csr_window;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (cmd.capture) begin
         hold_ff <= in_value;
      end
      if (cmd.pop) begin
         out_value_ff <= entry_ff[0];
         out_final_ff <= cmd.final_flag;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_final_result = out_final_ff;

endmodule

// File: rtl/core/kss_controller.sv
// ----------------------------------------------------------------------------
// kss_controller
// Sequences each request: optional pop of the minimum at acceptance, the
// sorted insert, and the drain after a request marked final.
// ----------------------------------------------------------------------------
module kss_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final_item,
   output logic                    req_ready,
   input  kss_pkg::kss_status_type status,
   output kss_pkg::kss_cmd_type    cmd
);
   import kss_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INSERT = 3'b010,
      ST_DRAIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      accept;

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && status.out_free;
      accept    = req_valid && req_ready;
   end

   always_comb begin
      state_in       = state_ff;
      last_in        = last_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               cmd.pop     = status.at_capacity;
               last_in     = req_final_item;
               state_in    = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = last_ff ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.pop        = 1'b1;
               cmd.final_flag = status.single_left;
               if (status.single_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// File: rtl/core/k_sorted_stream_sorter_core.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter_core
// Sorts a stream whose values lie at most window places from their sorted
// position, keeping up to min(window, MAX_WINDOW) + 1 values in order.
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, emitting the least held value when
// the store is full; then the insert state does the parallel sorted insert in
// the register chain. A request is not accepted while an earlier result still
// waits to be taken. A request marked final is followed by a drain that
// emits every held value in ascending order, one per cycle while results are
// taken, the last marked final_result. The window register may be written
// whenever the block is idle and takes effect on the next request.
module k_sorted_stream_sorter_core #(
   parameter int MAX_WINDOW = kss_pkg::DEFAULT_MAX_WINDOW
) (
   input logic        clock,
   input logic        reset,
   kss_req_if.sink    req_chan,
   kss_rsp_if.source  rsp_chan,
   kss_csr_if.sink    csr_chan
);
   import kss_pkg::*;

   kss_cmd_type    cmd;
   kss_status_type status;

   assign csr_chan.ready = 1'b1;

   kss_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_final_item (req_chan.final_item),
      .req_ready      (req_chan.ready),
      .status         (status),
      .cmd            (cmd)
   );

   kss_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_value         (req_chan.value),
      .csr_valid        (csr_chan.valid),
      .csr_window       (csr_chan.window),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_sorted_value (rsp_chan.sorted_value),
      .rsp_final_result (rsp_chan.final_result)
   );

`ifndef ASSERT_OFF
   a_pop_needs_free_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> status.out_free)
      else $error("Result register overwritten while a result was pending.");

   a_pop_insert_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.insert))
      else $error("Pop and insert issued in the same cycle.");

   a_final_on_last_entry : assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && cmd.final_flag) |-> status.single_left)
      else $error("Final result marked while entries remain.");
`endif

endmodule
